>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is asserted.
`define STR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent check that stays live through reset.
`define STR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/str_pkg.sv
// Package for the segment tree range reducer: sizes, codes and the identity and combine functions.
package str_pkg;

    localparam int LEAF_AW = 10;
    localparam int LEAVES  = 1 << LEAF_AW;
    localparam int NODE_AW = LEAF_AW + 1;
    localparam int NODES   = 2 * LEAVES;
    localparam int DATA_W  = 32;

    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [NODE_AW-1:0] t_node;
    typedef logic [NODE_AW:0]   t_ptr;

    // func codes
    localparam logic [1:0] FUNC_SET   = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_RANGE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // combine_mode codes
    localparam logic MODE_MIN = 1'b0;
    localparam logic MODE_SUM = 1'b1;

    localparam t_data INT_MAX = t_data'(32'h7FFF_FFFF);

    function automatic t_data identity(input logic mode);
        return (mode == MODE_SUM) ? t_data'(0) : INT_MAX;
    endfunction

    // min is a signed compare; sum wraps
    function automatic t_data combine(input logic mode, input t_data a, input t_data b);
        t_data res;
        if (mode == MODE_SUM) begin
            res = a + b;
        end else begin
            res = ($signed(a) <= $signed(b)) ? a : b;
        end
        return res;
    endfunction

endpackage

>>> sv/segment_tree_range_reduce.sv
// Segment tree range reducer (min or sum) over a node RAM; a range query makes up to two
//   node reads per tree level on one read port; the update walk does one ancestor per cycle
//   (sibling read, parent write).
// A new word is taken once the previous result sits in the output register.
// Synchronous active-low reset; afterwards a clearing pass writes INT_MAX into all 2048
//   nodes, one per cycle, and input is held off until the pass is done.
module segment_tree_range_reduce
    import str_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_func,
    input  logic [LEAF_AW-1:0]    i_index,
    input  logic [LEAF_AW:0]      i_right_bound,
    input  logic signed [31:0]    i_value,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_result
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_UP   = 3'd3;
    localparam logic [2:0] S_LEAF = 3'd4;
    localparam logic [2:0] S_QRY  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // control state
    logic [2:0] r_state, n_state;
    t_node      r_clr_addr, n_clr_addr;
    logic       r_mode, n_mode;
    logic       r_out_valid, n_out_valid;
    logic       r_acc, n_acc;
    logic       r_side, n_side;

    // datapath registers
    t_node r_node, n_node;
    t_data r_cur, n_cur;
    t_data r_res, n_res;
    t_data r_val, n_val;
    t_data r_result, n_result;
    t_ptr  r_l, n_l;
    t_ptr  r_r, n_r;

    // RAM port signals
    logic  ram_we;
    t_node ram_waddr;
    t_data ram_wdata;
    t_node ram_raddr;
    t_data ram_rdata;

    // helpers
    t_node         leaf;
    t_node         parent;
    t_data         add_sum;
    t_data         up_val;
    t_data         acc_val;
    logic [LEAF_AW:0] rb_clamp;
    t_ptr          right_dec;

    str_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // leaf j lives in node LEAVES + j
    assign leaf     = {1'b1, i_index};
    assign parent   = r_node >> 1;
    assign add_sum  = ram_rdata + r_val;
    assign up_val   = combine(r_mode, r_cur, ram_rdata);
    assign acc_val  = combine(r_mode, r_res, ram_rdata);
    assign rb_clamp = (i_right_bound > (LEAF_AW+1)'(LEAVES)) ? (LEAF_AW+1)'(LEAVES)
                                                              : i_right_bound;
    assign right_dec = r_r - t_ptr'(1);

    // next-state and RAM access
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_mode      = r_mode;
        n_out_valid = r_out_valid;
        n_acc       = 1'b0;
        n_side      = r_side;
        n_node      = r_node;
        n_cur       = r_cur;
        n_res       = r_res;
        n_val       = r_val;
        n_result    = r_result;
        n_l         = r_l;
        n_r         = r_r;
        ram_we      = 1'b0;
        ram_waddr   = r_node;
        ram_wdata   = r_cur;
        ram_raddr   = r_node;

        if (i_cfg_we) begin
            n_mode = i_cfg_data;
        end

        // output word taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = INT_MAX;
                n_clr_addr = r_clr_addr + t_node'(1);
                if (r_clr_addr == t_node'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_node = leaf;
                    n_val  = t_data'(i_value);
                    case (i_func)
                        FUNC_SET: begin
                            // write the leaf, fetch its sibling in the same cycle
                            ram_we    = 1'b1;
                            ram_waddr = leaf;
                            ram_wdata = t_data'(i_value);
                            ram_raddr = leaf ^ t_node'(1);
                            n_cur     = t_data'(i_value);
                            n_res     = t_data'(i_value);
                            n_state   = S_UP;
                        end
                        FUNC_ADD: begin
                            ram_raddr = leaf;
                            n_state   = S_ADD;
                        end
                        FUNC_READ: begin
                            ram_raddr = leaf;
                            n_state   = S_LEAF;
                        end
                        default: begin
                            n_res = identity(r_mode);
                            if ({1'b0, i_index} < rb_clamp) begin
                                n_l     = {2'b01, i_index};
                                n_r     = t_ptr'(LEAVES) + t_ptr'(rb_clamp);
                                n_side  = 1'b0;
                                n_state = S_QRY;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                    endcase
                end
            end
            S_ADD: begin
                ram_we    = 1'b1;
                ram_waddr = r_node;
                ram_wdata = add_sum;
                ram_raddr = r_node ^ t_node'(1);
                n_cur     = add_sum;
                n_res     = add_sum;
                n_state   = S_UP;
            end
            S_UP: begin
                // sibling data is here: write the parent, fetch the parent's sibling
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = up_val;
                ram_raddr = parent ^ t_node'(1);
                n_cur     = up_val;
                n_node    = parent;
                if (parent == t_node'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_LEAF: begin
                n_res   = ram_rdata;
                n_state = S_FIN;
            end
            S_QRY: begin
                // fold in the node fetched last cycle
                if (r_acc) begin
                    n_res = acc_val;
                end
                if (!r_side) begin
                    if (r_l >= r_r) begin
                        n_state = S_FIN;
                    end else begin
                        if (r_l[0]) begin
                            ram_raddr = r_l[NODE_AW-1:0];
                            n_acc     = 1'b1;
                            n_l       = r_l + t_ptr'(1);
                        end
                        n_side = 1'b1;
                    end
                end else begin
                    if (r_r[0]) begin
                        ram_raddr = right_dec[NODE_AW-1:0];
                        n_acc     = 1'b1;
                        n_r       = right_dec >> 1;
                    end else begin
                        n_r = r_r >> 1;
                    end
                    n_l    = r_l >> 1;
                    n_side = 1'b0;
                end
            end
            S_FIN: begin
                // wait for the output register to be free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_result    = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_mode      <= MODE_MIN;
            r_out_valid <= 1'b0;
            r_acc       <= 1'b0;
            r_side      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
            r_side      <= n_side;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_cur    <= n_cur;
        r_res    <= n_res;
        r_val    <= n_val;
        r_result <= n_result;
        r_l      <= n_l;
        r_r      <= n_r;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = $signed(r_result);

endmodule

>>> sv/str_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module str_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/str_chk.sv
// Port-level checker for the segment tree range reducer, bound to the top level.
`include "assert_macros.svh"

module str_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic signed [31:0]    o_result
);

    logic [1:0] r_pend;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else if (in_acc && !out_acc) begin
            r_pend <= r_pend + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    `STR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result), "result dropped or changed while stalled")
    `STR_ASSERT(a_no_phantom, i_clk, i_rst_n, o_out_valid |-> r_pend != 2'd0, "result without an accepted word")
    `STR_ASSERT(a_pend_bound, i_clk, i_rst_n, r_pend != 2'd3, "more than two words in flight")
    `STR_ASSERT_ALWAYS(a_clear_hold, i_clk, !i_rst_n |=> !o_in_ready, "input taken during clearing pass")

endmodule

bind segment_tree_range_reduce str_chk u_str_chk (.*);
